### design/lprl_pkg.sv
// Shared types and constants for the LRU page recency list.
package lprl_pkg;

  localparam int unsigned NUM_ENTRIES = 64;
  localparam int unsigned PAGE_BITS   = 20;
  localparam int unsigned FRAME_BITS  = 6;

  typedef enum logic [1:0] {
    KIND_TOUCH  = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_EVICT  = 2'd2,
    KIND_REMOVE = 2'd3
  } kind_e;

  typedef struct packed {
    logic                  valid;
    logic [PAGE_BITS-1:0]  page;
    logic [FRAME_BITS-1:0] frame;
  } entry_t;

  typedef struct packed {
    logic                 cmp_en;
    logic [PAGE_BITS-1:0] cmp_page;
    logic                 exec;
    kind_e                kind;
    logic                 any_hit;
  } cell_ctrl_t;

endpackage

### design/lprl_cell.sv
// One slot of the recency list: holds an entry, compares it and shifts to its neighbours.
module lprl_cell (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lprl_pkg::cell_ctrl_t ctrl_i,
  input  lprl_pkg::entry_t    left_i,
  input  lprl_pkg::entry_t    right_i,
  input  logic                le_i,
  input  logic                first_i,
  output lprl_pkg::entry_t    ent_o,
  output logic                hit_o
);
  import lprl_pkg::*;

  logic                  vld_q, vld_d;
  logic                  hit_q, hit_d;
  logic [PAGE_BITS-1:0]  page_q, page_d;
  logic [FRAME_BITS-1:0] frame_q, frame_d;

  always_comb begin
    vld_d   = vld_q;
    page_d  = page_q;
    frame_d = frame_q;
    hit_d   = hit_q;
    if (ctrl_i.cmp_en) begin
      hit_d = vld_q && (page_q == ctrl_i.cmp_page);
    end
    if (ctrl_i.exec) begin
      unique case (ctrl_i.kind)
        KIND_TOUCH: begin
          if (ctrl_i.any_hit && le_i) begin
            vld_d   = left_i.valid;
            page_d  = left_i.page;
            frame_d = left_i.frame;
          end
        end
        KIND_INSERT: begin
          vld_d   = left_i.valid;
          page_d  = left_i.page;
          frame_d = left_i.frame;
        end
        KIND_EVICT: begin
          if (vld_q && !right_i.valid) begin
            vld_d = 1'b0;
          end
        end
        KIND_REMOVE: begin
          if (ctrl_i.any_hit && (!le_i || first_i)) begin
            vld_d   = right_i.valid;
            page_d  = right_i.page;
            frame_d = right_i.frame;
          end
        end
        default: begin
          vld_d = vld_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      hit_q <= 1'b0;
    end else begin
      vld_q <= vld_d;
      hit_q <= hit_d;
    end
  end

  always_ff @(posedge clk_i) begin
    page_q  <= page_d;
    frame_q <= frame_d;
  end

  assign ent_o = '{valid: vld_q, page: page_q, frame: frame_q};
  assign hit_o = hit_q;

endmodule

### design/lru_page_recency_list.sv
// Top level of the LRU page recency list: command port, chain of cells, result register.
//
// At the accepting edge every cell compares its page with the item's page and holds the
// outcome; busy is then high for one cycle in which the first match is resolved across
// the chain and all cells shift at once. The result sits on found_o, frame_out_o and
// overflow_o for exactly one cycle, marked by done_o, and must be taken then: it is not
// held. A new item may be started in that same cycle. No clearing pass follows reset.
module lru_page_recency_list (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [1:0]                      kind_i,
  input  logic [lprl_pkg::PAGE_BITS-1:0]  page_i,
  input  logic [lprl_pkg::FRAME_BITS-1:0] frame_in_i,
  output logic                            done_o,
  output logic                            found_o,
  output logic [lprl_pkg::FRAME_BITS-1:0] frame_out_o,
  output logic                            overflow_o
);
  import lprl_pkg::*;

  logic                  busy_q;
  kind_e                 kind_q;
  logic [PAGE_BITS-1:0]  page_q;
  logic [FRAME_BITS-1:0] frame_q;

  logic                  done_q;
  logic                  found_q, found_d;
  logic [FRAME_BITS-1:0] frame_out_q, frame_out_d;
  logic                  overflow_q, overflow_d;

  entry_t                ent [NUM_ENTRIES];
  entry_t                head_ent;
  entry_t                tail_ent;
  cell_ctrl_t            ctrl;

  logic [NUM_ENTRIES-1:0] vld_vec;
  logic [NUM_ENTRIES-1:0] hit_vec;
  logic [NUM_ENTRIES-1:0] le_vec;
  logic [NUM_ENTRIES-1:0] first_vec;
  logic [NUM_ENTRIES-1:0] tail_vec;
  logic [NUM_ENTRIES-1:0] pick_vec;
  logic                   any_hit;
  logic [FRAME_BITS-1:0]  sel_frame;
  logic                   accept;

  assign accept = start && !busy_q;
  assign busy   = busy_q;

  // Inclusive prefix up to the first hit, and the first hit itself
  assign any_hit   = |hit_vec;
  assign le_vec    = hit_vec ^ (hit_vec - NUM_ENTRIES'(1));
  assign first_vec = hit_vec & le_vec;
  assign tail_vec  = vld_vec & ~(vld_vec >> 1);
  assign pick_vec  = (kind_q == KIND_EVICT) ? tail_vec : first_vec;

  always_comb begin
    sel_frame = '0;
    for (int i = 0; i < NUM_ENTRIES; i++) begin
      sel_frame = sel_frame | (pick_vec[i] ? ent[i].frame : '0);
    end
  end

  assign head_ent = '{valid: 1'b1, page: page_q,
                      frame: (kind_q == KIND_INSERT) ? frame_q : sel_frame};
  assign tail_ent = '0;

  assign ctrl = '{cmp_en: accept, cmp_page: page_i, exec: busy_q,
                  kind: kind_q, any_hit: any_hit};

  for (genvar g = 0; g < NUM_ENTRIES; g++) begin : g_cell
    entry_t left_ent;
    entry_t right_ent;
    if (g == 0) begin : g_head
      assign left_ent = head_ent;
    end else begin : g_mid_l
      assign left_ent = ent[g-1];
    end
    if (g == NUM_ENTRIES - 1) begin : g_tail
      assign right_ent = tail_ent;
    end else begin : g_mid_r
      assign right_ent = ent[g+1];
    end

    lprl_cell u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .ctrl_i  (ctrl),
      .left_i  (left_ent),
      .right_i (right_ent),
      .le_i    (le_vec[g]),
      .first_i (first_vec[g]),
      .ent_o   (ent[g]),
      .hit_o   (hit_vec[g])
    );

    assign vld_vec[g] = ent[g].valid;
  end

  always_comb begin
    found_d     = 1'b0;
    frame_out_d = '0;
    overflow_d  = 1'b0;
    unique case (kind_q)
      KIND_TOUCH: begin
        found_d = any_hit;
      end
      KIND_INSERT: begin
        overflow_d  = vld_vec[NUM_ENTRIES-1];
        frame_out_d = vld_vec[NUM_ENTRIES-1] ? ent[NUM_ENTRIES-1].frame : '0;
      end
      KIND_EVICT: begin
        found_d     = vld_vec[0];
        frame_out_d = sel_frame;
      end
      KIND_REMOVE: begin
        found_d     = any_hit;
        frame_out_d = sel_frame;
      end
      default: begin
        found_d = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q  <= kind_e'(kind_i);
      page_q  <= page_i;
      frame_q <= frame_in_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      done_q      <= 1'b0;
      found_q     <= 1'b0;
      frame_out_q <= '0;
      overflow_q  <= 1'b0;
    end else begin
      busy_q <= accept;
      done_q <= busy_q;
      if (busy_q) begin
        found_q     <= found_d;
        frame_out_q <= frame_out_d;
        overflow_q  <= overflow_d;
      end else begin
        found_q     <= 1'b0;
        frame_out_q <= '0;
        overflow_q  <= 1'b0;
      end
    end
  end

  assign done_o      = done_q;
  assign found_o     = found_q;
  assign frame_out_o = frame_out_q;
  assign overflow_o  = overflow_q;

  a_busy_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy |=> done_o)
    else $error("item in flight gave no result");

  a_done_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result shown while busy");

  a_ovf_done : assert property (@(posedge clk_i) disable iff (!rst_ni)
    overflow_o |-> (done_o && kind_q == KIND_INSERT))
    else $error("overflow outside an insert result");

  a_no_gap : assert property (@(posedge clk_i) disable iff (!rst_ni)
    ((vld_vec >> 1) & ~vld_vec) == '0)
    else $error("gap in valid entries");

  a_one_first : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(first_vec))
    else $error("more than one first match");

endmodule
